// ----- rtl/qeipid_pkg.sv -----
package qeipid_pkg;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TARGET = 3'd0;
  localparam cfg_idx_t CFG_GAIN_P = 3'd1;
  localparam cfg_idx_t CFG_GAIN_I = 3'd2;
  localparam cfg_idx_t CFG_GAIN_D = 3'd3;
  localparam cfg_idx_t CFG_MODE   = 3'd4;

  localparam int TARGET_BITS = 23;
  localparam int GAIN_BITS   = 16;
  localparam int MODE_BITS   = 2;

  localparam logic [GAIN_BITS-1:0] GAIN_P_RESET = 16'd7680;  // 30.0 in Q8.8

  // Drive modes / bridge codes
  localparam logic [MODE_BITS-1:0] MODE_STOP = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FWD  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BWD  = 2'd2;

  // Input item codes
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic LINE_A     = 1'b0;
  localparam logic WHEEL_LEFT = 1'b0;

  // Stream widths
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 120;
  localparam int OUT_CNT_BITS   = 24;
  localparam int PWM_BITS       = 8;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  typedef struct packed {
    logic tick;   // control tick, else encoder edge
    logic wheel;  // edge: 1 right wheel
    logic up;     // edge: count up
  } cmd_t;

  typedef struct packed {
    logic [TARGET_BITS-1:0] target;
    logic [GAIN_BITS-1:0]   kp;
    logic [GAIN_BITS-1:0]   ki;
    logic [GAIN_BITS-1:0]   kd;
    logic [MODE_BITS-1:0]   mode;
  } cfg_t;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic [OUT_CNT_BITS-1:0] error_right;
    logic [OUT_CNT_BITS-1:0] error_left;
    logic [OUT_CNT_BITS-1:0] count_right;
    logic [OUT_CNT_BITS-1:0] count_left;
    logic [MODE_BITS-1:0]    bridge_right;
    logic [MODE_BITS-1:0]    bridge_left;
    logic [PWM_BITS-1:0]     pwm_right;
    logic [PWM_BITS-1:0]     pwm_left;
  } res_t;

endpackage

// ----- rtl/quadrature_encoder_incremental_pid.sv -----
// Two-wheel quadrature counter with a velocity-form PID position loop per
// wheel. Each input transaction is either an encoder edge (in_tuser = 0),
// which moves one wheel's count by +1 or -1 from the line that changed and
// the current A/B levels, or a control tick (in_tuser = 1), which runs both
// controllers: e = sat(target - position) (the right wheel uses the absolute
// value of its count), acc += kp*(e-e1) + ki*e + kd*(e-2*e1+e2) with Q8.8
// gains and a saturating accumulator. Every input transaction yields exactly
// one output transaction carrying both duties (min(|acc|>>8, 255), zero
// while stopped), both bridge codes, both counts and the latest errors.
// Throughput is one transaction per clock while the output is not stalled,
// with edges and ticks freely mixed. Accepted items go into a four-entry
// command queue, so the input keeps accepting while the output is stalled,
// until the queue fills. The back end is a five-register pipeline
// (count/error, differences, gain multiplies, accumulate, output register);
// the accumulator and error history are each read and written in
// a single stage, so back-to-back ticks need no forwarding. Configuration
// writes are always accepted (cfg_ready = 1) and must only be issued when
// no transaction is in flight.
module quadrature_encoder_incremental_pid
  import qeipid_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int ACC_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [0] wheel_sel, [1] edge_line, [2] level_a, [3] level_b, [7:4] zero
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  // [0] op
  input  logic                      in_tuser,

  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [7:0] pwm_left, [15:8] pwm_right, [17:16] bridge_left,
  // [19:18] bridge_right, [43:20] count_left, [67:44] count_right,
  // [91:68] error_left, [115:92] error_right, [119:116] zero
  output logic [OUT_TDATA_BITS-1:0] out_tdata,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  // Config registers; indexes past drive_mode are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= '0;
      cfg_r.kp     <= GAIN_P_RESET;
      cfg_r.ki     <= '0;
      cfg_r.kd     <= '0;
      cfg_r.mode   <= MODE_STOP;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET: cfg_r.target <= cfg_data[TARGET_BITS-1:0];
        CFG_GAIN_P: cfg_r.kp     <= cfg_data[GAIN_BITS-1:0];
        CFG_GAIN_I: cfg_r.ki     <= cfg_data[GAIN_BITS-1:0];
        CFG_GAIN_D: cfg_r.kd     <= cfg_data[GAIN_BITS-1:0];
        CFG_MODE:   cfg_r.mode   <= cfg_data[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front: decode the edge direction and enqueue
  qeipid_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  qeipid_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  // Back: counters, PID pipeline, output register
  qeipid_back #(
    .COUNT_BITS (COUNT_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {{(OUT_TDATA_BITS-$bits(res_t)){1'b0}}, res};

  // Reset empties the pipeline and the queue
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // A stopped bridge always carries zero duty on both wheels
  a_stop_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.bridge_left == MODE_STOP) |->
      (res.pwm_left == '0 && res.pwm_right == '0))
    else $error("nonzero duty while stopped");

  // Both bridges follow the same mode
  a_bridges_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.bridge_left == res.bridge_right))
    else $error("bridge codes differ");

endmodule

// ----- rtl/qeipid_front.sv -----
module qeipid_front
  import qeipid_pkg::*;
(
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_BITS-1:0] in_tdata,
  input  logic                     in_tuser,
  input  logic                     q_full,
  output logic                     q_push,
  output cmd_t                     q_cmd
);

  logic same_lvl;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign same_lvl  = (in_tdata[2] == in_tdata[3]);

  // Edge on A counts up when levels agree, edge on B when they differ
  always_comb begin
    q_cmd.tick  = (in_tuser == OP_TICK);
    q_cmd.wheel = in_tdata[0];
    q_cmd.up    = (in_tdata[1] == LINE_A) ? same_lvl : !same_lvl;
  end

endmodule

// ----- rtl/qeipid_queue.sv -----
module qeipid_queue
  import qeipid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  cmd_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_r, rd_r;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/qeipid_back.sv -----
module qeipid_back
  import qeipid_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int ACC_BITS   = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_tvalid,
  input  logic out_tready,
  output res_t res
);

  localparam int CB   = COUNT_BITS;
  localparam int DW   = ((CB > TARGET_BITS) ? CB : TARGET_BITS) + 2;
  localparam int PW   = CB + 2 + GAIN_BITS + 1;
  localparam int SUMW = PW + 2;
  localparam int AW   = ACC_BITS;
  localparam int SW   = ((AW > SUMW) ? AW : SUMW) + 1;

  localparam logic signed [CB-1:0] E_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] E_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [AW-1:0] A_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] A_MIN = {1'b1, {(AW-1){1'b0}}};

  logic adv;

  // Loop state
  logic signed [CB-1:0] pos_r [2];
  logic signed [CB-1:0] pos_nxt [2];
  logic signed [CB-1:0] e1_r [2];
  logic signed [CB-1:0] e2_r [2];
  logic signed [AW-1:0] acc_r [2];
  logic signed [AW-1:0] acc_nxt [2];

  // Stage 1 comb
  logic signed [CB-1:0] r_neg, r_abs;
  logic signed [CB-1:0] posv [2];
  logic signed [DW-1:0] diff [2];
  logic signed [CB-1:0] e_new [2];

  // Stage 2 comb
  logic signed [CB:0]   d1_c [2];
  logic signed [CB+1:0] d2_c [2];

  // Stage 4 comb
  logic signed [SUMW-1:0] delta [2];
  logic signed [SW-1:0]   sum [2];

  // Output comb
  logic signed [AW:0]   mag [2];
  logic [PWM_BITS-1:0]  pwm [2];
  logic                 running;
  res_t                 res_nxt;

  logic signed [GAIN_BITS:0] kp_s, ki_s, kd_s;

  // Pipeline registers
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_tick_r, s2_tick_r, s3_tick_r;
  logic signed [CB-1:0]   s1_e_r [2], s1_cnt_r [2];
  logic signed [CB-1:0]   s2_e_r [2], s2_cnt_r [2], s2_err_r [2];
  logic signed [CB:0]     s2_d1_r [2];
  logic signed [CB+1:0]   s2_d2_r [2];
  logic signed [PW-1:0]   s3_p_r [2], s3_i_r [2], s3_d_r [2];
  logic signed [CB-1:0]   s3_cnt_r [2], s3_err_r [2];
  logic signed [AW-1:0]   s4_acc_r [2];
  logic signed [CB-1:0]   s4_cnt_r [2], s4_err_r [2];
  res_t                   res_r;

  assign adv        = !out_v_r || out_tready;
  assign q_pop      = adv && q_valid;
  assign out_tvalid = out_v_r;
  assign res        = res_r;

  assign kp_s = signed'({1'b0, cfg.kp});
  assign ki_s = signed'({1'b0, cfg.ki});
  assign kd_s = signed'({1'b0, cfg.kd});

  // Stage 1: count update on edges, saturated error on ticks
  always_comb begin
    r_neg   = -pos_r[1];
    r_abs   = pos_r[1][CB-1] ? r_neg : pos_r[1];
    posv[0] = pos_r[0];
    posv[1] = r_abs[CB-1] ? E_MAX : r_abs;
    for (int w = 0; w < 2; w++) begin
      pos_nxt[w] = pos_r[w];
      if (q_pop && !q_cmd.tick && (q_cmd.wheel == 1'(w))) begin
        pos_nxt[w] = pos_r[w] + (q_cmd.up ? CB'(1) : {CB{1'b1}});
      end
      diff[w] = signed'(DW'(cfg.target)) - DW'(posv[w]);
      if ((&diff[w][DW-1:CB-1]) || !(|diff[w][DW-1:CB-1])) begin
        e_new[w] = diff[w][CB-1:0];
      end else begin
        e_new[w] = diff[w][DW-1] ? E_MIN : E_MAX;
      end
    end
  end

  // Stage 2: error differences
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      d1_c[w] = (CB+1)'(s1_e_r[w]) - (CB+1)'(e1_r[w]);
      d2_c[w] = (CB+2)'(s1_e_r[w]) - ((CB+2)'(e1_r[w]) <<< 1) + (CB+2)'(e2_r[w]);
    end
  end

  // Stage 4: accumulate with saturation
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      delta[w] = SUMW'(s3_p_r[w]) + SUMW'(s3_i_r[w]) + SUMW'(s3_d_r[w]);
      sum[w]   = SW'(acc_r[w]) + SW'(delta[w]);
      acc_nxt[w] = acc_r[w];
      if (s3_tick_r) begin
        if ((&sum[w][SW-1:AW-1]) || !(|sum[w][SW-1:AW-1])) begin
          acc_nxt[w] = sum[w][AW-1:0];
        end else begin
          acc_nxt[w] = sum[w][SW-1] ? A_MIN : A_MAX;
        end
      end
    end
  end

  // Output: duty = min(|acc| >> 8, 255), bridge from mode
  always_comb begin
    running = (cfg.mode == MODE_FWD) || (cfg.mode == MODE_BWD);
    for (int w = 0; w < 2; w++) begin
      mag[w] = s4_acc_r[w][AW-1] ? -((AW+1)'(s4_acc_r[w])) : (AW+1)'(s4_acc_r[w]);
      pwm[w] = (|mag[w][AW:16]) ? {PWM_BITS{1'b1}} : mag[w][15:8];
    end
    res_nxt.pwm_left     = running ? pwm[0] : '0;
    res_nxt.pwm_right    = running ? pwm[1] : '0;
    res_nxt.bridge_left  = running ? cfg.mode : MODE_STOP;
    res_nxt.bridge_right = running ? cfg.mode : MODE_STOP;
    res_nxt.count_left   = OUT_CNT_BITS'(s4_cnt_r[0]);
    res_nxt.count_right  = OUT_CNT_BITS'(s4_cnt_r[1]);
    res_nxt.error_left   = OUT_CNT_BITS'(s4_err_r[0]);
    res_nxt.error_right  = OUT_CNT_BITS'(s4_err_r[1]);
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int w = 0; w < 2; w++) begin
        pos_r[w] <= '0;
        e1_r[w]  <= '0;
        e2_r[w]  <= '0;
        acc_r[w] <= '0;
      end
    end else begin
      for (int w = 0; w < 2; w++) begin
        pos_r[w] <= pos_nxt[w];
      end
      if (adv) begin
        s1_v_r  <= q_valid;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r;
        s4_v_r  <= s3_v_r;
        out_v_r <= s4_v_r;
        if (s1_v_r && s1_tick_r) begin
          for (int w = 0; w < 2; w++) begin
            e2_r[w] <= e1_r[w];
            e1_r[w] <= s1_e_r[w];
          end
        end
        if (s3_v_r && s3_tick_r) begin
          for (int w = 0; w < 2; w++) begin
            acc_r[w] <= acc_nxt[w];
          end
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tick_r <= q_cmd.tick;
      s2_tick_r <= s1_tick_r;
      s3_tick_r <= s2_tick_r;
      res_r     <= res_nxt;
      for (int w = 0; w < 2; w++) begin
        s1_e_r[w]   <= e_new[w];
        s1_cnt_r[w] <= pos_nxt[w];

        s2_e_r[w]   <= s1_e_r[w];
        s2_d1_r[w]  <= d1_c[w];
        s2_d2_r[w]  <= d2_c[w];
        s2_cnt_r[w] <= s1_cnt_r[w];
        s2_err_r[w] <= s1_tick_r ? s1_e_r[w] : e1_r[w];

        s3_p_r[w]   <= PW'(kp_s) * PW'(s2_d1_r[w]);
        s3_i_r[w]   <= PW'(ki_s) * PW'(s2_e_r[w]);
        s3_d_r[w]   <= PW'(kd_s) * PW'(s2_d2_r[w]);
        s3_cnt_r[w] <= s2_cnt_r[w];
        s3_err_r[w] <= s2_err_r[w];

        s4_acc_r[w] <= acc_nxt[w];
        s4_cnt_r[w] <= s3_cnt_r[w];
        s4_err_r[w] <= s3_err_r[w];
      end
    end
  end

endmodule

// ----- tb/tb_quadrature_encoder_incremental_pid.sv -----
module tb_quadrature_encoder_incremental_pid
  import qeipid_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COUNT_W     = 24;
  localparam int     ACC_W       = 32;
  localparam int     PIPE_LAT    = 5;          // input accept -> out_tvalid
  localparam int     HOLD_CYCLES = 64;         // long receiver hold-off
  localparam int     RES_BITS    = $bits(res_t);
  localparam int     MAX_PRINTS  = 200;
  localparam longint LIMIT_NS    = 5_000_000;

  localparam logic                   WHEEL_RIGHT = ~WHEEL_LEFT;
  localparam logic                   LINE_B      = ~LINE_A;
  localparam logic [MODE_BITS-1:0]   MODE_SPARE  = 2'd3;   // undefined code, acts as stop
  localparam logic [TARGET_BITS-1:0] TARGET_MAX  = '1;
  localparam logic [GAIN_BITS-1:0]   GAIN_MAX    = '1;
  localparam longint                 CNT_MAX     = (longint'(1) <<< (COUNT_W - 1)) - 1;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata   = '0;
  logic                      in_tuser   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

  quadrature_encoder_incremental_pid #(
    .COUNT_BITS (COUNT_W),
    .ACC_BITS   (ACC_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("** quadrature_encoder_incremental_pid: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Status predictor: own copy of the wheel counts, error history and
  // accumulators, plus the register file as seen through cfg writes.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]   wheel_cnt [2] = '{default: '0};
  longint               err_last  [2] = '{default: 0};
  longint               err_prev  [2] = '{default: 0};
  longint               acc_q8    [2] = '{default: 0};
  longint               target_cnt = 0;
  longint               kp_q8      = GAIN_P_RESET;
  longint               ki_q8      = 0;
  longint               kd_q8      = 0;
  logic [MODE_BITS-1:0] drive_code = MODE_STOP;

  res_t status_due [$];       // predicted status frames, oldest first
  int   n_bad     = 0;
  int   n_checked = 0;

  function automatic longint clamp_signed(longint v, int bits);
    longint top;
    top = (longint'(1) <<< (bits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic logic [PWM_BITS-1:0] duty_of_acc(longint acc);
    longint mag;
    mag = (acc < 0 ? -acc : acc) >>> 8;
    return (mag > 255) ? 8'd255 : PWM_BITS'(mag);
  endfunction

  // Applies one input transaction and returns the status frame it produces.
  function automatic res_t next_status(logic op, logic wheel, logic line,
                                       logic lvl_a, logic lvl_b);
    res_t   s;
    longint pos, e, delta;
    logic   up, running;
    if (op == OP_EDGE) begin
      // A edge counts up when the lines agree, B edge when they differ
      up = (line == LINE_A) ? (lvl_a == lvl_b) : (lvl_a != lvl_b);
      wheel_cnt[wheel] = up ? wheel_cnt[wheel] + 1'b1 : wheel_cnt[wheel] - 1'b1;
    end else begin
      for (int w = 0; w < 2; w++) begin
        pos = longint'($signed(wheel_cnt[w]));
        if (w == 1) begin
          // right wheel runs on the magnitude of its count
          if (pos < 0) pos = -pos;
          if (pos > CNT_MAX) pos = CNT_MAX;
        end
        e = clamp_signed(target_cnt - pos, COUNT_W);
        delta = kp_q8 * (e - err_last[w]) + ki_q8 * e
              + kd_q8 * (e - 2 * err_last[w] + err_prev[w]);
        acc_q8[w]   = clamp_signed(acc_q8[w] + delta, ACC_W);
        err_prev[w] = err_last[w];
        err_last[w] = e;
      end
    end
    running        = (drive_code == MODE_FWD) || (drive_code == MODE_BWD);
    s              = '0;
    s.pwm_left     = running ? duty_of_acc(acc_q8[0]) : '0;
    s.pwm_right    = running ? duty_of_acc(acc_q8[1]) : '0;
    s.bridge_left  = running ? drive_code : MODE_STOP;
    s.bridge_right = running ? drive_code : MODE_STOP;
    s.count_left   = wheel_cnt[0];
    s.count_right  = wheel_cnt[1];
    s.error_left   = OUT_CNT_BITS'(err_last[0]);
    s.error_right  = OUT_CNT_BITS'(err_last[1]);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven with NBAs right after a rising edge; valid
  // is left high after a handshake so back-to-back transactions need no
  // second assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic op, logic wheel, logic line, logic lvl_a,
                           logic lvl_b, bit typed, res_t typed_res);
    res_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, lvl_b, lvl_a, line, wheel};
    do @(posedge clk); while (!in_tready);
    predicted = next_status(op, wheel, line, lvl_a, lvl_b);
    // hand-computed rows replace the prediction but the model still steps
    status_due.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TARGET: target_cnt = value[TARGET_BITS-1:0];
      CFG_GAIN_P: kp_q8      = value[GAIN_BITS-1:0];
      CFG_GAIN_I: ki_q8      = value[GAIN_BITS-1:0];
      CFG_GAIN_D: kd_q8      = value[GAIN_BITS-1:0];
      CFG_MODE:   drive_code = value[MODE_BITS-1:0];
      default: ;  // unmapped index, ignored
    endcase
  endtask

  // All five registers, upper bits sometimes filled with junk, and now and
  // then a write to an unmapped index.
  task automatic load_setup(logic [TARGET_BITS-1:0] target, logic [GAIN_BITS-1:0] gp,
                            logic [GAIN_BITS-1:0] gi, logic [GAIN_BITS-1:0] gd,
                            logic [MODE_BITS-1:0] mode);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : '0;
    write_reg(CFG_TARGET, {junk[CFG_DATA_BITS-1:TARGET_BITS], target});
    write_reg(CFG_GAIN_P, {junk[CFG_DATA_BITS-1:GAIN_BITS], gp});
    if ($urandom_range(0, 1))
      write_reg(cfg_idx_t'(CFG_MODE + $urandom_range(1, 3)), $urandom);
    write_reg(CFG_GAIN_I, {junk[CFG_DATA_BITS-1:GAIN_BITS], gi});
    write_reg(CFG_GAIN_D, {junk[CFG_DATA_BITS-1:GAIN_BITS], gd});
    write_reg(CFG_MODE, {junk[CFG_DATA_BITS-1:MODE_BITS], mode});
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every predicted frame has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  // Per-wheel line levels and run direction for well-formed quadrature.
  logic quad_a [2] = '{default: 1'b0};
  logic quad_b [2] = '{default: 1'b0};
  logic run_up [2] = '{default: 1'b1};

  task automatic random_items(int n, bit with_gaps);
    int   w, roll, burst, gap;
    logic ln;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (with_gaps && burst <= 0) begin
        burst = $urandom_range(1, 16);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // noise: any field combination
        send_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom_range(0, 1), 1'b0, '0);
      end else if (roll < 35) begin
        send_item(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom_range(0, 1), 1'b0, '0);
      end else begin
        // proper quadrature step in the wheel's current run direction;
        // toggling A steps up exactly when the new A equals B
        w = $urandom_range(0, 1);
        if ($urandom_range(0, 5) == 0) run_up[w] = ~run_up[w];
        if (((~quad_a[w]) == quad_b[w]) == run_up[w]) begin
          quad_a[w] = ~quad_a[w];
          ln = LINE_A;
        end else begin
          quad_b[w] = ~quad_b[w];
          ln = LINE_B;
        end
        send_item(OP_EDGE, w[0], ln, quad_a[w], quad_b[w], 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: cycles through random ready patterns (all-ready, sparse, dense)
  // and, on request, holds off for HOLD_CYCLES so the command queue fills.
  // ---------------------------------------------------------------------------
  bit          hold_go   = 1'b0;
  int          hold_left = 0;
  int          pat_age   = 0;
  logic [31:0] stall_pat = '1;
  logic [4:0]  pat_pos   = '0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = $urandom;
          2:       stall_pat = $urandom | $urandom;
          default: stall_pat = $urandom & $urandom;
        endcase
        pat_age = $urandom_range(40, 200);
      end
      pat_age--;
      out_tready <= stall_pat[pat_pos];
      pat_pos++;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned want);
    n_bad++;
    if (n_bad <= MAX_PRINTS)
      $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, n_checked, field, got, want);
  endtask

  always @(posedge clk) begin : status_check
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[RES_BITS-1:0];
      if (out_tdata[OUT_TDATA_BITS-1:RES_BITS] != '0)
        report_mismatch("tdata padding", out_tdata[OUT_TDATA_BITS-1:RES_BITS], 0);
      if (status_due.size() == 0) begin
        report_mismatch("transaction with none pending", out_tdata[63:0], 0);
      end else begin
        want = status_due.pop_front();
        if (got.pwm_left != want.pwm_left)
          report_mismatch("pwm_left", got.pwm_left, want.pwm_left);
        if (got.pwm_right != want.pwm_right)
          report_mismatch("pwm_right", got.pwm_right, want.pwm_right);
        if (got.bridge_left != want.bridge_left)
          report_mismatch("bridge_left", got.bridge_left, want.bridge_left);
        if (got.bridge_right != want.bridge_right)
          report_mismatch("bridge_right", got.bridge_right, want.bridge_right);
        if (got.count_left != want.count_left)
          report_mismatch("count_left", got.count_left, want.count_left);
        if (got.count_right != want.count_right)
          report_mismatch("count_right", got.count_right, want.count_right);
        if (got.error_left != want.error_left)
          report_mismatch("error_left", got.error_left, want.error_left);
        if (got.error_right != want.error_right)
          report_mismatch("error_right", got.error_right, want.error_right);
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows, run straight out of reset (target 0, stop mode). Rows with
  // typed set carry hand-computed counts; all other frame fields are zero
  // there because nothing has moved the errors yet.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic               op;
    logic               wheel;
    logic               line;
    logic               lvl_a;
    logic               lvl_b;
    logic               typed;
    logic [COUNT_W-1:0] cnt_l;
    logic [COUNT_W-1:0] cnt_r;
  } probe_t;

  localparam int N_PROBES = 17;
  localparam probe_t PROBE_ROWS [N_PROBES] = '{
    // tick with every don't-care field high: all zero
    {OP_TICK, WHEEL_RIGHT, LINE_B, 1'b1, 1'b1, 1'b1, 24'd0,        24'd0},
    // left wheel, each line with both level relations
    {OP_EDGE, WHEEL_LEFT,  LINE_A, 1'b0, 1'b0, 1'b1, 24'd1,        24'd0},
    {OP_EDGE, WHEEL_LEFT,  LINE_A, 1'b1, 1'b0, 1'b1, 24'd0,        24'd0},
    {OP_EDGE, WHEEL_LEFT,  LINE_B, 1'b1, 1'b1, 1'b1, 24'hFF_FFFF,  24'd0},
    {OP_EDGE, WHEEL_LEFT,  LINE_B, 1'b0, 1'b1, 1'b1, 24'd0,        24'd0},
    // right wheel, then below zero
    {OP_EDGE, WHEEL_RIGHT, LINE_A, 1'b1, 1'b1, 1'b1, 24'd0,        24'd1},
    {OP_EDGE, WHEEL_RIGHT, LINE_B, 1'b1, 1'b0, 1'b1, 24'd0,        24'd2},
    {OP_EDGE, WHEEL_RIGHT, LINE_A, 1'b0, 1'b1, 1'b1, 24'd0,        24'd1},
    {OP_EDGE, WHEEL_RIGHT, LINE_B, 1'b0, 1'b0, 1'b1, 24'd0,        24'd0},
    {OP_EDGE, WHEEL_RIGHT, LINE_B, 1'b1, 1'b1, 1'b1, 24'd0,        24'hFF_FFFF},
    {OP_EDGE, WHEEL_RIGHT, LINE_A, 1'b1, 1'b0, 1'b1, 24'd0,        24'hFF_FFFE},
    // ticks on a negative right count (absolute value path), e1/e2 history
    {OP_TICK, WHEEL_LEFT,  LINE_A, 1'b0, 1'b0, 1'b0, 24'd0,        24'd0},
    {OP_EDGE, WHEEL_LEFT,  LINE_A, 1'b1, 1'b1, 1'b0, 24'd0,        24'd0},
    {OP_TICK, WHEEL_RIGHT, LINE_A, 1'b1, 1'b0, 1'b0, 24'd0,        24'd0},
    {OP_TICK, WHEEL_LEFT,  LINE_B, 1'b0, 1'b1, 1'b0, 24'd0,        24'd0},
    {OP_EDGE, WHEEL_LEFT,  LINE_B, 1'b1, 1'b0, 1'b0, 24'd0,        24'd0},
    {OP_TICK, WHEEL_LEFT,  LINE_A, 1'b0, 1'b0, 1'b0, 24'd0,        24'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, then register settings with random
  // traffic. A fixed setting and random settings come first; the saturating
  // extremes come late since they leave the accumulators pinned.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    probe_t row;
    res_t   typed_res;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_PROBES; i++) begin
      row                   = PROBE_ROWS[i];
      typed_res             = '0;
      typed_res.count_left  = row.cnt_l;
      typed_res.count_right = row.cnt_r;
      send_item(row.op, row.wheel, row.line, row.lvl_a, row.lvl_b, row.typed, typed_res);
    end

    for (int ph = 0; ph < 9; ph++) begin
      drain_results();
      case (ph)
        0: load_setup(23'd20, GAIN_P_RESET, '0, '0, MODE_FWD);
        6: load_setup(TARGET_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, MODE_BWD);
        7: load_setup('0, GAIN_MAX, GAIN_MAX, GAIN_MAX, MODE_FWD);
        8: load_setup('0, '0, '0, '0, MODE_SPARE);
        default: begin
          load_setup(($urandom_range(0, 7) == 0) ? $urandom_range(0, TARGET_MAX)
                                                 : $urandom_range(0, 48),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAIN_MAX)
                                                 : $urandom_range(0, 2048),
                     $urandom_range(0, 32),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAIN_MAX)
                                                 : $urandom_range(0, 2048),
                     $urandom_range(0, 3));
        end
      endcase
      if (ph == 5) begin
        // receiver goes quiet while the sender keeps pushing back to back
        hold_go = 1'b1;
        random_items(30, 1'b0);
        random_items(30, 1'b1);
      end else begin
        random_items(60, 1'b1);
      end
    end

    drain_results();
    repeat (4 * PIPE_LAT) @(posedge clk);
    if (n_bad == 0)
      $display("** quadrature_encoder_incremental_pid: PASSED **");
    else
      $display("** quadrature_encoder_incremental_pid: FAILED **");
    $finish;
  end

endmodule
